// File: rtl/hsg_pkg.sv
`timescale 1ns / 1ps
package hsg_pkg;

  // Width of a prime from the table (largest entry is 311)
  localparam int unsigned PRIME_BITS = 9;
  localparam int unsigned PRIME_COUNT = 64;

  // Quotient bits resolved per cycle while splitting off a digit
  localparam int unsigned DIV_STEP_BITS = 4;

  // Configuration port
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned DIMS_BITS = 5;
  localparam int unsigned START_BITS = 32;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIMS_USED = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_INDEX = 2'd1;

  localparam int unsigned DIM_OUT_BITS = 4;
  localparam int unsigned COORD_BITS = 32;

  localparam logic [PRIME_BITS-1:0] PRIMES [PRIME_COUNT] = '{
    9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
    9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
    9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
    9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
    9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
    9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
    9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263,
    9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311
  };

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SETUP = 7'b0000010,
    ST_CHECK = 7'b0000100,
    ST_DIGIT = 7'b0001000,
    ST_ACCUM = 7'b0010000,
    ST_FINAL = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } hsg_state_e;

  typedef struct packed {
    logic start;     // word accepted: pick first dimension, reload index on restart
    logic setup;     // load index into the digit splitter, clear fraction
    logic dig_step;  // resolve DIV_STEP_BITS quotient bits
    logic accum;     // fold the finished digit into numerator and denominator
    logic fin_load;  // clear the fraction quotient
    logic fin_step;  // one bit of the fraction division
    logic emit;      // coordinate ready for the output register
  } hsg_cmd_t;

  typedef struct packed {
    logic work_zero;  // nothing left of the index to split
    logic last_dim;   // current dimension is the final one of the point
  } hsg_sts_t;

endpackage

// File: rtl/halton_sequence_generator.sv
`timescale 1ns / 1ps
// Sequence: each dimension runs setup, then for each base-p digit of the index (none for
//   index zero) a check, the digit division and an accumulate step, then a last check,
//   the fraction division one bit at a time and the emit into the output register.
// Throughput: one word in per point; the next word is taken once the last coordinate
//   has gone into the output register. Digit splitting and the fraction division set it.
// Reset: asynchronous, active low; dims_used 1, start_index 0, sample index 0, no output.
module halton_sequence_generator import hsg_pkg::*; #(
  parameter int unsigned MAX_DIMS = 16,
  parameter int unsigned INDEX_BITS = 32,
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  // request words
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     restart_i,
  // coordinate words
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [DIM_OUT_BITS-1:0]  dim_index_o,
  output logic [COORD_BITS-1:0]    coordinate_o,
  output logic                     last_o
);

  // The index is split into digits by a restoring divider that resolves
  // DIV_STEP_BITS quotient bits a cycle, so pad the dividend to a whole
  // number of those steps.
  localparam int unsigned DIG_CYCLES = (INDEX_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int unsigned WORK_BITS = DIG_CYCLES * DIV_STEP_BITS;

  logic [DIMS_BITS-1:0]    dims_used_q, dims_used_d;
  logic [START_BITS-1:0]   start_index_q, start_index_d;

  hsg_cmd_t cmd;
  hsg_sts_t sts;
  logic     busy;
  logic     out_free;

  logic [DIM_OUT_BITS-1:0] dp_dim;
  logic [COORD_BITS-1:0]   dp_coord;
  logic                    dp_last;

  logic                    out_valid_q, out_valid_d;
  logic [DIM_OUT_BITS-1:0] dim_index_q;
  logic [COORD_BITS-1:0]   coordinate_q;
  logic                    last_q;

  // Configuration: writes beyond the register list are dropped.
  // start_index only takes effect at the next restart.
  always_comb begin
    dims_used_d   = dims_used_q;
    start_index_d = start_index_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DIMS_USED: begin
          dims_used_d = cfg_wdata_i[DIMS_BITS-1:0];
        end
        CFG_START_INDEX: begin
          start_index_d = cfg_wdata_i[START_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_used_q   <= DIMS_BITS'(1);
      start_index_q <= '0;
    end else begin
      dims_used_q   <= dims_used_d;
      start_index_q <= start_index_d;
    end
  end

  // The sequencer runs one point at a time; a new request word is taken only
  // when it is idle, which may be while the last coordinate still waits.
  assign in_stall_o = busy;

  // The output register may be refilled in the same cycle it is drained.
  assign out_free = !out_valid_q || !out_stall_i;

  hsg_ctrl #(
    .DIG_CYCLES    (DIG_CYCLES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  hsg_datapath #(
    .MAX_DIMS      (MAX_DIMS),
    .INDEX_BITS    (INDEX_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .WORK_BITS     (WORK_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .restart_i     (restart_i),
    .dims_used_i   (dims_used_q),
    .start_index_i (start_index_q),
    .dim_index_o   (dp_dim),
    .coordinate_o  (dp_coord),
    .last_o        (dp_last)
  );

  // Output register: hold while stalled, load on emit, drop once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      dim_index_q  <= dp_dim;
      coordinate_q <= dp_coord;
      last_q       <= dp_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dim_index_o  = dim_index_q;
  assign coordinate_o = coordinate_q;
  assign last_o       = last_q;

  // A coordinate is never pushed into a full, stalled output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> out_free)
    else $error("coordinate emitted into a blocked output register");

  // Once a request word is taken the sequencer is busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted but sequencer not busy");

  // Emitting the final coordinate of a point frees the request side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && sts.last_dim) |=> !in_stall_o)
    else $error("sequencer still busy after final coordinate");

  // A freshly emitted coordinate carries the last flag the datapath reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> (out_valid_o && (last_o == $past(sts.last_dim))))
    else $error("output last flag does not match emitted dimension");

endmodule

// File: rtl/hsg_ctrl.sv
`timescale 1ns / 1ps
module hsg_ctrl import hsg_pkg::*; #(
  parameter int unsigned DIG_CYCLES = 8,
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_free_i,
  input  hsg_sts_t sts_i,
  output hsg_cmd_t cmd_o,
  output logic     busy_o
);

  localparam int unsigned MAX_CYC = (DIG_CYCLES > FRACTION_BITS) ? DIG_CYCLES : FRACTION_BITS;
  localparam int unsigned CTW = $clog2(MAX_CYC);

  hsg_state_e state_q, state_d;
  logic [CTW-1:0] ctr_q, ctr_d;

  always_comb begin
    state_d = state_q;
    ctr_d   = ctr_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.work_zero) begin
          cmd_o.fin_load = 1'b1;
          ctr_d = CTW'(FRACTION_BITS - 1);
          state_d = ST_FINAL;
        end else begin
          ctr_d = CTW'(DIG_CYCLES - 1);
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        cmd_o.dig_step = 1'b1;
        if (ctr_q == '0) begin
          state_d = ST_ACCUM;
        end else begin
          ctr_d = ctr_q - 1'b1;
        end
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d = ST_CHECK;
      end
      ST_FINAL: begin
        cmd_o.fin_step = 1'b1;
        if (ctr_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          ctr_d = ctr_q - 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          state_d = sts_i.last_dim ? ST_IDLE : ST_SETUP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ctr_q   <= '0;
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
    end
  end

endmodule

// File: rtl/hsg_datapath.sv
`timescale 1ns / 1ps
module hsg_datapath import hsg_pkg::*; #(
  parameter int unsigned MAX_DIMS = 16,
  parameter int unsigned INDEX_BITS = 32,
  parameter int unsigned FRACTION_BITS = 32,
  parameter int unsigned WORK_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hsg_cmd_t                 cmd_i,
  output hsg_sts_t                 sts_o,
  input  logic                     restart_i,
  input  logic [DIMS_BITS-1:0]     dims_used_i,
  input  logic [START_BITS-1:0]    start_index_i,
  output logic [DIM_OUT_BITS-1:0]  dim_index_o,
  output logic [COORD_BITS-1:0]    coordinate_o,
  output logic                     last_o
);

  localparam int unsigned DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned CW = $clog2(MAX_DIMS + 1);
  localparam int unsigned NDW = INDEX_BITS + PRIME_BITS;

  logic [INDEX_BITS-1:0]    index_q, index_d;
  logic [DW-1:0]            dim_q, dim_d;
  logic [WORK_BITS-1:0]     work_q, work_d;
  logic [PRIME_BITS-1:0]    digit_q, digit_d;
  logic [NDW-1:0]           num_q, num_d;
  logic [NDW-1:0]           den_q, den_d;
  logic [FRACTION_BITS-1:0] quo_q, quo_d;

  logic [PRIME_BITS-1:0]    prime;
  logic [CW-1:0]            count;
  logic [WORK_BITS-1:0]     work_s;
  logic [PRIME_BITS-1:0]    digit_s;
  logic [PRIME_BITS:0]      trial;
  logic [NDW:0]             fin_trial;
  logic                     fin_bit;

  assign prime = PRIMES[6'(dim_q)];

  // Clamp the dimension count to 1..MAX_DIMS
  always_comb begin
    if (dims_used_i == '0) begin
      count = CW'(1);
    end else if (32'(dims_used_i) > MAX_DIMS) begin
      count = CW'(MAX_DIMS);
    end else begin
      count = CW'(dims_used_i);
    end
  end

  assign sts_o.last_dim  = ((CW'(dim_q) + CW'(1)) == count);
  assign sts_o.work_zero = (work_q == '0);

  // Restoring division of the remaining index by the prime, a few bits a cycle.
  // The quotient shifts in behind the dividend; the remainder is the digit.
  always_comb begin
    work_s  = work_q;
    digit_s = digit_q;
    trial   = '0;
    for (int s = 0; s < DIV_STEP_BITS; s++) begin
      trial  = {digit_s, work_s[WORK_BITS-1]};
      work_s = {work_s[WORK_BITS-2:0], 1'b0};
      if (trial >= {1'b0, prime}) begin
        digit_s   = PRIME_BITS'(trial - {1'b0, prime});
        work_s[0] = 1'b1;
      end else begin
        digit_s = PRIME_BITS'(trial);
      end
    end
  end

  // One bit of floor(num * 2^F / den); num stays below den throughout
  assign fin_trial = {num_q, 1'b0};
  assign fin_bit   = (fin_trial >= {1'b0, den_q});

  always_comb begin
    index_d = index_q;
    dim_d   = dim_q;
    work_d  = work_q;
    digit_d = digit_q;
    num_d   = num_q;
    den_d   = den_q;
    quo_d   = quo_q;
    if (cmd_i.start) begin
      dim_d = '0;
      if (restart_i) begin
        index_d = INDEX_BITS'(start_index_i);
      end
    end
    if (cmd_i.setup) begin
      work_d  = WORK_BITS'(index_q);
      digit_d = '0;
      num_d   = '0;
      den_d   = NDW'(1);
    end
    if (cmd_i.dig_step) begin
      work_d  = work_s;
      digit_d = digit_s;
    end
    if (cmd_i.accum) begin
      num_d   = NDW'(num_q * NDW'(prime)) + NDW'(digit_q);
      den_d   = NDW'(den_q * NDW'(prime));
      digit_d = '0;
    end
    if (cmd_i.fin_load) begin
      quo_d = '0;
    end
    if (cmd_i.fin_step) begin
      quo_d = {quo_q[FRACTION_BITS-2:0], fin_bit};
      num_d = fin_bit ? NDW'(fin_trial - {1'b0, den_q}) : NDW'(fin_trial);
    end
    if (cmd_i.emit) begin
      if (sts_o.last_dim) begin
        index_d = index_q + 1'b1;
      end else begin
        dim_d = dim_q + 1'b1;
      end
    end
  end

  assign dim_index_o  = DIM_OUT_BITS'(dim_q);
  assign coordinate_o = COORD_BITS'(quo_q);
  assign last_o       = sts_o.last_dim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q <= '0;
      dim_q   <= '0;
    end else begin
      index_q <= index_d;
      dim_q   <= dim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    digit_q <= digit_d;
    num_q   <= num_d;
    den_q   <= den_d;
    quo_q   <= quo_d;
  end

endmodule

// File: tb/hsg_coord_checker.sv
`timescale 1ns / 1ps
module hsg_coord_checker import hsg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     restart_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [DIM_OUT_BITS-1:0]  dim_index_i,
  input  logic [COORD_BITS-1:0]    coordinate_i,
  input  logic                     last_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);

  localparam int unsigned MAX_DIMS = 16;
  localparam int unsigned BASES [MAX_DIMS] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53
  };

  typedef struct packed {
    logic [DIM_OUT_BITS-1:0] dim;
    logic [COORD_BITS-1:0]   coord;
    logic                    last;
  } coord_word_t;

  coord_word_t           coord_q [$];
  logic [DIMS_BITS-1:0]  dims_used;
  logic [START_BITS-1:0] start_index;
  logic [31:0]           sample_index;

  // Mirror the base-p digits of n about the radix point, 0.32 fraction, truncated.
  function automatic logic [COORD_BITS-1:0] mirror_index(input logic [31:0] n,
                                                         input int unsigned base);
    int unsigned       digits [32];
    int unsigned       ndig;
    longint unsigned   rest;
    longint unsigned   frac;
    rest = n;
    ndig = 0;
    frac = 0;
    while (rest != 0) begin
      digits[ndig] = int'(rest % base);
      rest = rest / base;
      ndig++;
    end
    // fold from the most significant digit inwards; nested floors stay exact
    for (int i = int'(ndig) - 1; i >= 0; i--) begin
      frac = ((longint'(digits[i]) << 32) + frac) / base;
    end
    return frac[COORD_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    $display("[%0t] coordinate check: %s", $time, msg);
  endtask

  task automatic predict_point(input logic reload);
    int unsigned count;
    coord_word_t w;
    if (reload) begin
      sample_index = start_index;
    end
    count = (dims_used == 0) ? 1 : (dims_used > MAX_DIMS) ? MAX_DIMS : dims_used;
    for (int unsigned j = 0; j < count; j++) begin
      w.dim   = DIM_OUT_BITS'(j);
      w.coord = mirror_index(sample_index, BASES[j]);
      w.last  = (j + 1 == count);
      coord_q = {coord_q, w};
    end
    sample_index = sample_index + 1;
  endtask

  task automatic check_coordinate();
    coord_word_t got;
    coord_word_t want;
    got = {dim_index_i, coordinate_i, last_i};
    if (coord_q.size() == 0) begin
      report_mismatch($sformatf("word with nothing expected: dim %0d value %h last %b",
                                got.dim, got.coord, got.last));
    end else begin
      want = coord_q.pop_front();
      if (got !== want) begin
        report_mismatch($sformatf("dim %0d/%0d value %h/%h last %b/%b (got/expected)",
                                  got.dim, want.dim, got.coord, want.coord,
                                  got.last, want.last));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_used    = 1;
      start_index  = '0;
      sample_index = '0;
      coord_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // retire before predicting: a word leaving now belongs to an older point
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        check_coordinate();
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        predict_point(restart_i);
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_DIMS_USED) begin
          dims_used = cfg_wdata_i[DIMS_BITS-1:0];
        end else if (cfg_index_i == CFG_START_INDEX) begin
          start_index = cfg_wdata_i[START_BITS-1:0];
        end
      end
      pending_o = coord_q.size();
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb import hsg_pkg::*;;

  // Long enough that a sixteen-dimension point completes behind it, so the block
  // fills and must hold off further request words.
  localparam int unsigned HOLD_CYCLES = 4000;
  // Worst-case point latency; wait this long at the end to catch stray words.
  localparam int unsigned DRAIN_CYCLES = 2500;
  localparam int unsigned RANDOM_PHASES = 14;
  localparam int unsigned WORDS_PER_PHASE = 20;
  localparam int unsigned PRESSURE_PHASE = 5;
  // Register indexes beyond the list: writes there must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     restart = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [DIM_OUT_BITS-1:0]  dim_index;
  logic [COORD_BITS-1:0]    coordinate;
  logic                     last;

  logic                     hold_start = 1'b0;
  int unsigned              hold_left = 0;
  int unsigned              send_idle_pct = 0;
  int unsigned              recv_stall_pct = 0;
  int unsigned              fail_count;
  int unsigned              pending;

  halton_sequence_generator dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .restart_i    (restart),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .dim_index_o  (dim_index),
    .coordinate_o (coordinate),
    .last_o       (last)
  );

  hsg_coord_checker coord_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .restart_i    (restart),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .dim_index_i  (dim_index),
    .coordinate_i (coordinate),
    .last_i       (last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: stall at random, or hold off completely for a counted stretch
  // once the stimulus pulses hold_start.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (hold_start) begin
        hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_stall <= hold_start || (hold_left > 1) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #80_000_000;
    $display("** halton_sequence_generator: FAILED **");
    $finish;
  end

  task automatic set_idling(input idle_mode_e mode);
    unique case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct <= 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 67;
        recv_stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct <= 67;
      end
      default: begin
        send_idle_pct = 7;
        recv_stall_pct <= 7;
      end
    endcase
  endtask

  // Offer one request word and hold it until the block takes it. While idle,
  // wiggle the payload so a stray capture would show up.
  task automatic send_word(input logic reload);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      restart  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= reload;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  // Drop valid and wait until every expected coordinate has left the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Well-formed run: restart first, then mostly continue with the odd reload.
  task automatic send_run(input int unsigned n);
    send_word(1'b1);
    for (int unsigned k = 1; k < n; k++) begin
      send_word($urandom_range(9) == 0);
    end
  endtask

  initial begin : stimulus
    int unsigned pick;
    logic [CFG_DATA_BITS-1:0] dims_val;
    logic [CFG_DATA_BITS-1:0] start_val;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: one dimension from index zero, which mirrors to zero.
    set_idling(IDLE_NONE);
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b1);

    // Top of the index range over all sixteen dimensions. The new start value
    // must not touch the running index until a restart; then wrap to zero.
    wait_idle();
    write_reg(CFG_START_INDEX, 32'hFFFF_FFFF);
    write_reg(CFG_DIMS_USED, 32'd16);
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);

    // Zero dimensions behaves as one.
    wait_idle();
    write_reg(CFG_DIMS_USED, 32'd0);
    send_word(1'b0);

    // Oversized dimension count saturates; alternating bit pattern as start.
    wait_idle();
    write_reg(CFG_DIMS_USED, 32'hFFFF_FFFF);
    write_reg(CFG_START_INDEX, 32'hAAAA_5555);
    send_word(1'b1);

    // Writes to indexes past the list are ignored.
    wait_idle();
    write_reg(CFG_DIMS_USED, 32'd2);
    write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_HI, $urandom);
    send_word(1'b0);

    // Small indexes, which have only one or two base-p digits.
    wait_idle();
    write_reg(CFG_START_INDEX, 32'd1);
    write_reg(CFG_DIMS_USED, 32'd4);
    send_word(1'b1);
    send_word(1'b0);

    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      // Mostly few dimensions to keep the run short; now and then the
      // full sixteen or an out-of-range count.
      pick = $urandom_range(99);
      if (pick < 70) begin
        dims_val = $urandom_range(4, 1);
      end else if (pick < 80) begin
        dims_val = $urandom_range(15, 5);
      end else if (pick < 90) begin
        dims_val = 16;
      end else begin
        dims_val = ($urandom_range(1) == 0) ? 32'd0 : 32'($urandom_range(31, 17));
      end
      pick = $urandom_range(3);
      if (pick < 2) begin
        start_val = $urandom;
      end else if (pick == 2) begin
        start_val = $urandom_range(40);
      end else begin
        start_val = 32'hFFFF_FFFF - $urandom_range(30);
      end
      write_reg(CFG_DIMS_USED, dims_val);
      write_reg(CFG_START_INDEX, start_val);
      set_idling(idle_mode_e'(ph % 4));

      if (ph == PRESSURE_PHASE) begin
        // Hold off the receiver while words keep coming, so the block backs up.
        fork
          begin
            hold_start <= 1'b1;
            @(posedge clk);
            hold_start <= 1'b0;
          end
          send_run(WORDS_PER_PHASE);
        join
      end else begin
        send_run(WORDS_PER_PHASE);
      end
    end

    wait_idle();
    recv_stall_pct <= 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** halton_sequence_generator: PASSED **");
    end else begin
      $display("** halton_sequence_generator: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/hsg_pkg.sv
rtl/hsg_ctrl.sv
rtl/hsg_datapath.sv
rtl/halton_sequence_generator.sv
tb/hsg_coord_checker.sv
tb/tb.sv
